[rtl/sms_pkg.sv]
// Package for the stable merge sorter: data width, default depth and
// the state types of the top level and the sort sequencer.
// No dependencies.
`default_nettype none

package sms_pkg;

   localparam int DATA_W    = 32;
   localparam int DEPTH_DEF = 64;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_SORT,
      ST_FETCH,
      ST_SHOW
   } top_state_type;

   typedef enum logic [1:0] {
      SQ_IDLE,
      SQ_PASS,
      SQ_RUN,
      SQ_READ
   } seq_state_type;

   // second half of the read/compare loop is encoded separately so the
   // encoding above stays two bits wide
   typedef enum logic {
      PH_ADDR,
      PH_MERGE
   } merge_phase_type;

endpackage

`default_nettype wire

[rtl/sms_ram.sv]
// Generic RAM: one write port, two read ports, registered read data.
// No dependencies.
`default_nettype none

module sms_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
   input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
   output logic      [WIDTH-1:0]         rdata_a,
   output logic      [WIDTH-1:0]         rdata_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_a <= mem_ff[raddr_a];
      rdata_b <= mem_ff[raddr_b];
   end

endmodule

`default_nettype wire

[rtl/sms_sorter.sv]
// Bottom-up stable merge sort sequencer with one shared signed comparator
// over two ping-pong buffers. Uses sms_pkg and sms_ram.
// Host side loads buffer 0 and reads the result while the sequencer idles.
`default_nettype none

module sms_sorter
   import sms_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [$clog2(DEPTH+1)-1:0] count,
   output logic                            done,
   input  wire logic                       host_we,
   input  wire logic [$clog2(DEPTH)-1:0]   host_waddr,
   input  wire logic [DATA_W-1:0]          host_wdata,
   input  wire logic [$clog2(DEPTH)-1:0]   host_raddr,
   output logic      [DATA_W-1:0]          host_rdata
);

   localparam int AW = $clog2(DEPTH);
   localparam int SW = $clog2(3 * DEPTH);

   seq_state_type   state_ff, state_in;
   merge_phase_type phase_ff, phase_in;
   logic [SW-1:0] n_ff, n_in;
   logic [SW-1:0] width_ff, width_in;
   logic [SW-1:0] lo_ff, lo_in;
   logic [SW-1:0] mid_ff, mid_in;
   logic [SW-1:0] hi_ff, hi_in;
   logic [SW-1:0] i_ff, i_in;
   logic [SW-1:0] j_ff, j_in;
   logic [SW-1:0] k_ff, k_in;
   logic          src_ff, src_in;

   logic [SW-1:0]     run_mid, run_hi;
   logic              a_ok, b_ok, take_b, wr_en, idle;
   logic [DATA_W-1:0] b0_a, b0_b, b1_a, b1_b, rd_a, rd_b, wr_data;

   assign idle    = (state_ff == SQ_IDLE);
   assign rd_a    = src_ff ? b1_a : b0_a;
   assign rd_b    = src_ff ? b1_b : b0_b;
   assign a_ok    = (i_ff < mid_ff);
   assign b_ok    = (j_ff < hi_ff);
   // ties take the left run, which keeps the sort stable
   assign take_b  = b_ok && (!a_ok || ($signed(rd_b) < $signed(rd_a)));
   assign wr_data = take_b ? rd_b : rd_a;
   assign run_mid = ((lo_ff + width_ff) < n_ff) ? (lo_ff + width_ff) : n_ff;
   assign run_hi  = ((lo_ff + (width_ff << 1)) < n_ff) ? (lo_ff + (width_ff << 1)) : n_ff;
   assign host_rdata = src_ff ? b1_a : b0_a;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SQ_IDLE;
         phase_ff <= PH_ADDR;
         src_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         src_ff   <= src_in;
      end
      n_ff     <= n_in;
      width_ff <= width_in;
      lo_ff    <= lo_in;
      mid_ff   <= mid_in;
      hi_ff    <= hi_in;
      i_ff     <= i_in;
      j_ff     <= j_in;
      k_ff     <= k_in;
   end

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      n_in     = n_ff;
      width_in = width_ff;
      lo_in    = lo_ff;
      mid_in   = mid_ff;
      hi_in    = hi_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      k_in     = k_ff;
      src_in   = src_ff;
      done     = 1'b0;
      wr_en    = 1'b0;
      case (state_ff)
         SQ_IDLE: begin
            if (start) begin
               n_in     = SW'(count);
               width_in = SW'(1);
               src_in   = 1'b0;
               state_in = SQ_PASS;
            end
         end
         SQ_PASS: begin
            if (width_ff >= n_ff) begin
               done     = 1'b1;
               state_in = SQ_IDLE;
            end else begin
               lo_in    = '0;
               state_in = SQ_RUN;
            end
         end
         SQ_RUN: begin
            if (lo_ff >= n_ff) begin
               width_in = width_ff << 1;
               src_in   = ~src_ff;
               state_in = SQ_PASS;
            end else begin
               mid_in   = run_mid;
               hi_in    = run_hi;
               i_in     = lo_ff;
               j_in     = run_mid;
               k_in     = lo_ff;
               phase_in = PH_ADDR;
               state_in = SQ_READ;
            end
         end
         SQ_READ: begin
            case (phase_ff)
               PH_ADDR: begin
                  phase_in = PH_MERGE;
               end
               PH_MERGE: begin
                  if (!a_ok && !b_ok) begin
                     lo_in    = hi_ff;
                     state_in = SQ_RUN;
                  end else begin
                     wr_en = 1'b1;
                     k_in  = k_ff + SW'(1);
                     if (take_b) begin
                        j_in = j_ff + SW'(1);
                     end else begin
                        i_in = i_ff + SW'(1);
                     end
                  end
                  phase_in = PH_ADDR;
               end
               default: phase_in = PH_ADDR;
            endcase
         end
         default: state_in = SQ_IDLE;
      endcase
   end

   sms_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_buf0 (
      .clock   (clock),
      .we      (idle ? host_we : (wr_en && src_ff)),
      .waddr   (idle ? host_waddr : k_ff[AW-1:0]),
      .wdata   (idle ? host_wdata : wr_data),
      .raddr_a (idle ? host_raddr : i_ff[AW-1:0]),
      .raddr_b (j_ff[AW-1:0]),
      .rdata_a (b0_a),
      .rdata_b (b0_b)
   );

   sms_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_buf1 (
      .clock   (clock),
      .we      (wr_en && !src_ff),
      .waddr   (k_ff[AW-1:0]),
      .wdata   (wr_data),
      .raddr_a (idle ? host_raddr : i_ff[AW-1:0]),
      .raddr_b (j_ff[AW-1:0]),
      .rdata_a (b1_a),
      .rdata_b (b1_b)
   );

endmodule

`default_nettype wire

[rtl/stable_merge_sorter.sv]
// Stable merge sorter, top level: load, sort and emit control.
// Uses sms_pkg and sms_sorter (which holds the two sms_ram buffers).
//
// Usage: feed a sequence of signed 32-bit values on the req_ channel, one
// item per cycle while req_tready is high, with req_tlast on the final one.
// Up to DEPTH values are kept; further values are dropped and rsp_tuser
// (overflowed) is then set on every result of that sequence.
// After the last item req_tready drops while the block sorts. The sort is a
// bottom-up merge with one shared comparator in ceil(log2 n) passes.
// Results then leave in ascending order on rsp_, equal values in arrival
// order, rsp_tlast on the final one. Each result passes a buffer read, then
// a show state; rsp_tvalid holds with stable data while rsp_tready is low.
// Once the last result is taken the block clears and accepts a new sequence.
// Reset (synchronous, active high) empties the buffer and clears the flag;
// buffer contents are not cleared and need not be.
`default_nettype none

module stable_merge_sorter
   import sms_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   input  wire logic signed [DATA_W-1:0] req_tdata,  // [31:0] value
   input  wire logic                     req_tlast,  // last_in
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   output logic signed [DATA_W-1:0]      rsp_tdata,  // [31:0] sorted_value
   output logic                          rsp_tlast,  // last_out
   output logic                          rsp_tuser   // [0] overflowed
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   top_state_type   state_ff, state_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            drop_ff, drop_in;
   logic [AW-1:0]   ptr_ff, ptr_in;

   logic              req_acc, rsp_acc, has_room, sort_start, sort_done, at_end;
   logic [DATA_W-1:0] rd_data;

   assign req_tready = (state_ff == ST_LOAD);
   assign rsp_tvalid = (state_ff == ST_SHOW);
   assign req_acc    = req_tvalid && req_tready;
   assign rsp_acc    = rsp_tvalid && rsp_tready;
   assign has_room   = (count_ff < CW'(DEPTH));
   assign sort_start = req_acc && req_tlast;
   assign at_end     = ((CW'(ptr_ff) + CW'(1)) == count_ff);
   assign rsp_tdata  = $signed(rd_data);
   assign rsp_tlast  = at_end;
   assign rsp_tuser  = drop_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         count_ff <= '0;
         drop_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         drop_ff  <= drop_in;
      end
      ptr_ff <= ptr_in;
   end

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      drop_in  = drop_ff;
      ptr_in   = ptr_ff;
      case (state_ff)
         ST_LOAD: begin
            if (req_acc) begin
               if (has_room) begin
                  count_in = count_ff + CW'(1);
               end else begin
                  drop_in = 1'b1;
               end
               if (req_tlast) begin
                  state_in = ST_SORT;
               end
            end
         end
         ST_SORT: begin
            if (sort_done) begin
               ptr_in   = '0;
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            state_in = ST_SHOW;
         end
         ST_SHOW: begin
            if (rsp_acc) begin
               if (at_end) begin
                  count_in = '0;
                  drop_in  = 1'b0;
                  state_in = ST_LOAD;
               end else begin
                  ptr_in   = ptr_ff + AW'(1);
                  state_in = ST_FETCH;
               end
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   // read address stays on ptr while a result waits, so the RAM output holds
   sms_sorter #(
      .DEPTH (DEPTH)
   ) u_sorter (
      .clock      (clock),
      .reset      (reset),
      .start      (sort_start),
      .count      (count_in),
      .done       (sort_done),
      .host_we    (req_acc && has_room),
      .host_waddr (count_ff[AW-1:0]),
      .host_wdata (req_tdata),
      .host_raddr (ptr_ff),
      .host_rdata (rd_data)
   );

endmodule

`default_nettype wire
